// ===== hdl/sbda_pkg.sv =====
// Shared types and constants for the signed binary to decimal ASCII converter.
`default_nettype none

package sbda_pkg;

  localparam int WordBits   = 32;
  localparam int CharBits   = 6;
  // Decimal digits needed for a magnitude of up to 2^(WordBits-1).
  localparam int DigitCount = ((WordBits - 1) * 1233) / 4096 + 1;
  localparam int BcdBits    = DigitCount * 4;
  localparam int IdxBits    = (DigitCount > 1) ? $clog2(DigitCount) : 1;
  localparam int CntBits    = $clog2(WordBits);
  localparam int QueueDepth = 2;
  localparam int PtrBits    = 1;
  localparam int FillBits   = $clog2(QueueDepth + 1);

  localparam logic [CharBits-1:0] AsciiZero  = CharBits'(48);
  localparam logic [CharBits-1:0] AsciiMinus = CharBits'(45);

  // One classified value waiting for conversion.
  typedef struct packed {
    logic                negative;
    logic [WordBits-1:0] magnitude;
  } sbda_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_PREP,
    ST_SIGN,
    ST_DIGITS
  } sbda_state_e;

endpackage

`default_nettype wire

// ===== hdl/sbda_front.sv =====
// Front end: accepts input words and splits them into sign and magnitude.
`default_nettype none

module sbda_front import sbda_pkg::*; (
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [31:0]         value_i,
  input  wire logic                q_full_i,
  output logic                     q_push_o,
  output sbda_item_t               q_item_o
);

  logic [WordBits-1:0] word;

  assign word       = value_i[WordBits-1:0];
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i & ~q_full_i;

  // Negation in WordBits unsigned bits gives 2^(WordBits-1) for the most negative value.
  always_comb begin
    q_item_o.negative  = word[WordBits-1];
    q_item_o.magnitude = word[WordBits-1] ? (~word + WordBits'(1)) : word;
  end

endmodule

`default_nettype wire

// ===== hdl/sbda_queue.sv =====
// Short queue between the front end and the conversion engine.
`default_nettype none

module sbda_queue import sbda_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire sbda_item_t item_i,
  output logic            full_o,
  input  wire logic       pop_i,
  output logic            empty_o,
  output sbda_item_t      item_o
);

  sbda_item_t           mem_q [QueueDepth];
  logic [PtrBits-1:0]   wr_ptr_q, rd_ptr_q;
  logic [FillBits-1:0]  fill_q;
  logic                 do_push, do_pop;

  assign full_o  = (fill_q == FillBits'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign item_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PtrBits'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PtrBits'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill_q <= fill_q + FillBits'(1);
        2'b01:   fill_q <= fill_q - FillBits'(1);
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sbda_back.sv =====
// Back end: double-dabble conversion and character emission.
`default_nettype none

module sbda_back import sbda_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire sbda_item_t           q_item_i,
  output logic                      q_pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [CharBits-1:0]       character_o,
  output logic                      last_o
);

  sbda_state_e          state_q, state_d;
  logic [WordBits-1:0]  mag_q, mag_d;
  logic [BcdBits-1:0]   bcd_q, bcd_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [IdxBits-1:0]   idx_q, idx_d;
  logic                 neg_q, neg_d;
  logic [CharBits-1:0]  char_q, char_d;
  logic                 last_q, last_d;
  logic                 ovalid_q, ovalid_d;

  logic [BcdBits-1:0]   bcd_adj;
  logic [IdxBits-1:0]   top_idx;
  logic [3:0]           cur_digit;
  logic                 out_free;

  assign out_valid_o = ovalid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign out_free    = ~ovalid_q | ~out_stall_i;

  // Add-3 correction on every digit before each shift.
  always_comb begin
    logic [3:0] nib;
    for (int i = 0; i < DigitCount; i++) begin
      nib = bcd_q[i*4 +: 4];
      bcd_adj[i*4 +: 4] = (nib >= 4'd5) ? (nib + 4'd3) : nib;
    end
  end

  // Highest nonzero digit; zero keeps a single digit.
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < DigitCount; i++) begin
      if (bcd_q[i*4 +: 4] != 4'd0) begin
        top_idx = IdxBits'(i);
      end
    end
  end

  assign cur_digit = bcd_q[idx_q*4 +: 4];

  always_comb begin
    state_d  = state_q;
    mag_d    = mag_q;
    bcd_d    = bcd_q;
    cnt_d    = cnt_q;
    idx_d    = idx_q;
    neg_d    = neg_q;
    char_d   = char_q;
    last_d   = last_q;
    ovalid_d = ovalid_q & out_stall_i;
    q_pop_o  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          mag_d   = q_item_i.magnitude;
          neg_d   = q_item_i.negative;
          bcd_d   = '0;
          cnt_d   = '0;
          state_d = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        bcd_d = {bcd_adj[BcdBits-2:0], mag_q[WordBits-1]};
        mag_d = {mag_q[WordBits-2:0], 1'b0};
        cnt_d = cnt_q + CntBits'(1);
        if (cnt_q == CntBits'(WordBits - 1)) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        idx_d   = top_idx;
        state_d = neg_q ? ST_SIGN : ST_DIGITS;
      end
      ST_SIGN: begin
        if (out_free) begin
          char_d   = AsciiMinus;
          last_d   = 1'b0;
          ovalid_d = 1'b1;
          state_d  = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (out_free) begin
          char_d   = AsciiZero + CharBits'(cur_digit);
          last_d   = (idx_q == '0);
          ovalid_d = 1'b1;
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - IdxBits'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

endmodule

`default_nettype wire

// ===== hdl/signed_binary_to_decimal_ascii.sv =====
// Top level of the signed binary to decimal ASCII converter.
//
// Input channel: in_valid_i / in_stall_o with value_i, a 32-bit two's
// complement word. A transfer happens on a rising edge with valid high and
// stall low. Output channel: out_valid_o / out_stall_i with character_o
// (ASCII '-' or '0'..'9' in 6 bits) and last_o, set on the final character.
// A negative value starts with '-'; zero gives a single '0'; no terminator.
//
// Timing: the front end classifies a word in the transfer cycle and parks it
// in a two-entry queue. The back end pops it, runs a shift-and-add-3
// conversion over the whole magnitude, locates the leading digit in a
// separate state and then emits one character per cycle while the receiver
// does not stall, 1 to 11 of them. The queue lets up to two further words
// be taken while one is in work.
//
// Reset (rst_ni, asynchronous, active low) empties the queue and drops any
// pending character. A stalled receiver holds the output register steady;
// the back end waits, and the front end stalls once the queue is full.
`default_nettype none

module signed_binary_to_decimal_ascii import sbda_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [31:0]         value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [CharBits-1:0]      character_o,
  output logic                     last_o
);

  sbda_item_t push_item, pop_item;
  logic       q_push, q_full, q_pop, q_empty;

  // Sign/magnitude split feeding the queue.
  sbda_front u_front (
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .value_i    (value_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (push_item)
  );

  sbda_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (pop_item)
  );

  // Conversion engine and registered character output.
  sbda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb_signed_binary_to_decimal_ascii.sv =====
// Self-checking testbench for the signed binary to decimal ASCII converter.
module tb_signed_binary_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  import sbda_pkg::*;

  localparam int ClkHalf       = 4;     // 8 ns period
  localparam int ResetCycles   = 5;
  localparam int RandomWords   = 190;
  localparam int HoldAtWord    = 40;    // random word index that triggers the long hold
  localparam int HoldCycles    = 400;   // receiver hold-off, long enough to back up the input
  localparam int DrainCycles   = 60;    // one full conversion plus slack
  localparam int WatchdogLimit = 3000;  // quiet cycles before declaring a hang
  localparam int DirCount      = 23;

  // One expected character on the output channel.
  typedef struct packed {
    logic [CharBits-1:0] ch;
    logic                last;
  } char_due_t;

  // Directed word; text is filled only where the answer is obvious,
  // empty text means the predictor supplies the expected characters.
  typedef struct {
    logic [31:0] value;
    string       text;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [31:0]         value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic [CharBits-1:0] character_o;
  logic                last_o;

  char_due_t chars_due[$];
  char_due_t want;
  int        failures;
  int        words_sent;
  int        negatives_sent;
  int        chars_checked;
  int        text_len;
  int        longest_text;
  int        input_stall_cycles;
  int        quiet_cycles;
  bit        hold_request;

  dir_row_t directed_rows [DirCount] = '{
    '{32'd0,             "0"},
    '{32'd1,             "1"},
    '{-32'sd1,           "-1"},
    '{32'h7FFF_FFFF,     "2147483647"},
    '{32'h8000_0000,     "-2147483648"},
    '{32'h8000_0001,     ""},
    '{32'h7FFF_FFFE,     ""},
    '{32'd9,             ""},
    '{32'd10,            ""},
    '{-32'sd9,           ""},
    '{-32'sd10,          ""},
    '{32'd99,            ""},
    '{32'd100,           ""},
    '{-32'sd100,         ""},
    '{32'd999999999,     ""},
    '{32'd1000000000,    ""},
    '{-32'sd999999999,   ""},
    '{-32'sd1000000000,  ""},
    '{32'h5555_5555,     ""},
    '{32'hAAAA_AAAA,     ""},
    '{32'd12345678,      ""},
    '{-32'sd87654321,    ""},
    '{32'd7,             ""}
  };

  signed_binary_to_decimal_ascii dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #ClkHalf clk_i = 1'b1;
    #ClkHalf clk_i = 1'b0;
  end

  // Predictor: decimal text of a two's complement word. The magnitude is
  // taken as an unsigned 32-bit quantity, so 0x8000_0000 negates to itself
  // and reads as 2^31. Digits are peeled least significant first.
  function automatic void predict_decimal_text(input logic [31:0] w);
    logic        negative;
    logic [31:0] mag;
    logic [3:0]  digits[$];
    negative = w[31];
    mag      = negative ? (~w + 32'd1) : w;
    do begin
      digits.push_front(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 0);
    if (negative) chars_due.push_back('{AsciiMinus, 1'b0});
    foreach (digits[i])
      chars_due.push_back('{AsciiZero + CharBits'(digits[i]), i == digits.size() - 1});
  endfunction

  // Expected characters typed straight from a string.
  function automatic void queue_typed_text(input string s);
    for (int i = 0; i < s.len(); i++)
      chars_due.push_back('{CharBits'(s[i]), i == s.len() - 1});
  endfunction

  // Offer one word and hold it until the transfer; then idle for gap cycles.
  // Valid is only lowered when a gap follows, so back-to-back words keep it high.
  // Stall is read mid-cycle, where it already holds its value for the next edge.
  task automatic send_word(input logic [31:0] w, input string text, input int gap);
    bit stalled;
    in_valid_i <= 1'b1;
    value_i    <= w;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
      if (stalled) input_stall_cycles++;
    end while (stalled);
    words_sent++;
    if (w[31]) negatives_sent++;
    if (text.len() != 0) queue_typed_text(text);
    else predict_decimal_text(w);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Sender gap: mostly none or short, now and then a long pause.
  function automatic int pick_gap();
    case ($urandom_range(9))
      6, 7:    return $urandom_range(1, 3);
      8:       return $urandom_range(4, 12);
      9:       return $urandom_range(30, 100);
      default: return 0;
    endcase
  endfunction

  // Output checker: each transfer is compared against the oldest expectation.
  // Sampled mid-cycle; outputs and stall only move on rising edges.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (chars_due.size() == 0) begin
        $error("unexpected character: actual 0x%0h last %0b", character_o, last_o);
        failures++;
      end else begin
        want = chars_due.pop_front();
        if (character_o !== want.ch) begin
          $error("character: expected %0d actual %0d", want.ch, character_o);
          failures++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b actual %0b", want.last, last_o);
          failures++;
        end
      end
      chars_checked++;
      text_len++;
      if (last_o) begin
        if (text_len > longest_text) longest_text = text_len;
        text_len = 0;
      end
    end
  end

  // Receiver: random stall runs plus free-running stretches; once, on
  // request from the sender, a long hold that backs the pipeline up until
  // the front end stalls its input.
  initial begin
    bit hold_done;
    hold_done   = 1'b0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        case ($urandom_range(9))
          0, 1, 2: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(1, 3)) @(posedge clk_i);
          end
          3: begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(15, 60)) @(posedge clk_i);
          end
          4, 5: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(40, 120)) @(posedge clk_i);
          end
          default: begin
            out_stall_i <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk_i);
          end
        endcase
      end
    end
  end

  // Watchdog: any transfer on either channel counts as progress.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("signed_binary_to_decimal_ascii regression: fail");
    $finish;
  end

  initial begin
    logic [31:0] w;
    logic [31:0] pow10;
    int          kind;
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    value_i            = '0;
    failures           = 0;
    words_sent         = 0;
    negatives_sent     = 0;
    chars_checked      = 0;
    text_len           = 0;
    longest_text       = 0;
    input_stall_cycles = 0;
    hold_request       = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: zero, both extremes and their neighbors, digit-count edges.
    foreach (directed_rows[i])
      send_word(directed_rows[i].value, directed_rows[i].text, pick_gap());

    // Random: full-range words mixed with small values, powers of ten and
    // their neighbors, and words near the extremes, so every text length
    // from 1 to 11 characters shows up.
    for (int n = 0; n < RandomWords; n++) begin
      if (n == HoldAtWord) hold_request = 1'b1;
      kind = $urandom_range(5);
      case (kind)
        0, 1: w = $urandom;
        2:    w = 32'($urandom_range(0, 20));
        3: begin
          pow10 = 32'd1;
          repeat ($urandom_range(0, 9)) pow10 = pow10 * 32'd10;
          w = pow10 + 32'($urandom_range(0, 2)) - 32'd1;
        end
        4:    w = 32'($urandom_range(0, 99999));
        default: begin
          if ($urandom_range(1)) w = 32'h7FFF_FFFF - 32'($urandom_range(0, 15));
          else w = 32'h8000_0000 + 32'($urandom_range(0, 15));
        end
      endcase
      if (kind >= 2 && kind <= 4 && $urandom_range(1)) w = -w;
      // During the hold keep offering back to back so the input really stalls.
      send_word(w, "", (n >= HoldAtWord && n < HoldAtWord + 8) ? 0 : pick_gap());
    end
    in_valid_i <= 1'b0;

    while (chars_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d words (%0d negative), %0d characters, longest text %0d chars",
             words_sent, negatives_sent, chars_checked, longest_text);
    $display("input held off for %0d cycles while the receiver stalled", input_stall_cycles);
    if (failures == 0) begin
      $display("signed_binary_to_decimal_ascii regression: pass");
    end else begin
      $display("signed_binary_to_decimal_ascii regression: fail");
    end
    $finish;
  end

endmodule
